/* hdl/ntb_pkg.sv */
// ----------------------------------------------------------------------------
// ntb_pkg
// Shared constants, item kind codes and helpers for the NSEC type bitmap
// builder.
// ----------------------------------------------------------------------------
package ntb_pkg;

  // Item kind field
  localparam int KIND_W = 2;
  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

  // Field widths
  localparam int TYPE_W = 16;
  localparam int BYTE_W = 8;

  // Window geometry: 256 windows of up to 32 bitmap octets
  localparam int WIN_N    = 256;
  localparam int WIN_W    = 8;
  localparam int OCT_N    = 32;
  localparam int OCT_IW   = 5;
  localparam int LEN_W    = 6;
  localparam int POS_W    = 6;
  localparam int BITMAP_W = OCT_N * BYTE_W;
  localparam int ROW_W    = BITMAP_W + LEN_W;

  // Presence search works on groups of 16 windows
  localparam int GRP_N  = 16;
  localparam int GRP_IW = 4;

  localparam logic [BYTE_W-1:0] OCT_TOP_BIT = 8'h80;
  localparam logic [BYTE_W-1:0] LAST_WIN    = 8'hFF;

  // Index of the lowest set bit of a 16-bit vector (zero when none is set)
  function automatic logic [GRP_IW-1:0] first_set16(input logic [GRP_N-1:0] v);
    logic [GRP_IW-1:0] idx;
    idx = '0;
    for (int i = GRP_N - 1; i >= 0; i--) begin
      if (v[i]) idx = GRP_IW'(i);
    end
    return idx;
  endfunction

endpackage

/* hdl/nsec_type_bitmap_builder_core.sv */
// ----------------------------------------------------------------------------
// nsec_type_bitmap_builder_core
// Builds the NSEC type bitmap of a set of record types and streams its wire
// encoding one byte per read item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries kind and type_code. A clear item
//   empties the set, an insert item adds type_code; neither gives a result.
//   A read item gives one result on the output channel (out_valid/out_ready):
//   the next byte of the encoding (window, length, bitmap octets, windows in
//   ascending order), last_byte on its final byte, empty_set when no type is
//   held. Insert and clear restart reading at the first byte.
//   Timing: one item at a time. Insert reads, modifies and writes one 262-bit
//   row of the window memory. A read finds the next present window through a
//   256-bit presence vector in two 16-wide steps (repeated once when the
//   search wraps), fetches the row, and runs a second search for the
//   following window when a window ends. Reset clears the presence vector,
//   so all windows read as absent at once; no clearing pass is needed.
//   A result waits in the output register while the receiver stalls; clear
//   and insert items are still taken, a further read holds until it drains.
// ----------------------------------------------------------------------------
module nsec_type_bitmap_builder_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ntb_pkg::KIND_W-1:0]   kind,
  input  logic [ntb_pkg::TYPE_W-1:0]   type_code,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ntb_pkg::BYTE_W-1:0]   wire_byte,
  output logic                         last_byte,
  output logic                         empty_set
);
  import ntb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WR,
    S_FIND,
    S_FIND2,
    S_EMIT,
    S_OUT
  } state_t;

  state_t              state;
  logic [TYPE_W-1:0]   ins_code;
  logic [WIN_N-1:0]    present;
  logic [WIN_W-1:0]    rw;
  logic [POS_W-1:0]    rp;
  logic [WIN_W-1:0]    srch_start;
  logic                srch_wrap;
  logic                srch_next;
  logic [GRP_IW-1:0]   srch_grp;
  logic [WIN_W-1:0]    cur_w;
  logic [BYTE_W-1:0]   res_byte;
  logic                res_last;
  logic                res_empty;
  logic [WIN_W-1:0]    rw_pend;
  logic [POS_W-1:0]    rp_pend;

  // Window row memory: bitmap octets in the low bits, length on top
  logic [ROW_W-1:0]    row_mem [WIN_N];
  logic [ROW_W-1:0]    row_rdata;
  logic                rd_valid;
  logic                mem_re;
  logic                mem_we;
  logic [WIN_W-1:0]    mem_raddr;
  logic [ROW_W-1:0]    mem_wdata;

  assign in_ready = (state == S_IDLE);

  // Presence search: lowest present window at or above srch_start
  logic [GRP_N-1:0]    grp_any;
  logic [GRP_N-1:0]    in_bits;
  logic [GRP_N-1:0]    above;
  logic [GRP_N-1:0]    grp2_bits;
  logic                found;
  logic [WIN_W-1:0]    found_w;

  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      grp_any[g] = |present[g*GRP_N +: GRP_N];
    end
    in_bits   = present[{srch_start[WIN_W-1:GRP_IW], 4'b0000} +: GRP_N]
                & (16'hFFFF << srch_start[GRP_IW-1:0]);
    above     = grp_any & (16'hFFFE << srch_start[WIN_W-1:GRP_IW]);
    grp2_bits = present[{srch_grp, 4'b0000} +: GRP_N];
    found     = ((state == S_FIND) && (|in_bits)) || (state == S_FIND2);
    if (state == S_FIND2) begin
      found_w = {srch_grp, first_set16(grp2_bits)};
    end else begin
      found_w = {srch_start[WIN_W-1:GRP_IW], first_set16(in_bits)};
    end
  end

  // Insert: merge one bit into the fetched row and grow the length
  logic [OCT_IW-1:0]   ins_oct;
  logic [BYTE_W-1:0]   ins_mask;
  logic [ROW_W-1:0]    base_row;
  logic [LEN_W-1:0]    base_len;
  logic [LEN_W-1:0]    oct_p1;

  always_comb begin
    ins_oct  = ins_code[7:3];
    ins_mask = OCT_TOP_BIT >> ins_code[2:0];
    base_row = rd_valid ? row_rdata : '0;
    base_len = base_row[ROW_W-1 -: LEN_W];
    oct_p1   = {1'b0, ins_oct} + 6'd1;
    for (int k = 0; k < OCT_N; k++) begin
      mem_wdata[k*BYTE_W +: BYTE_W] = base_row[k*BYTE_W +: BYTE_W]
          | ((OCT_IW'(k) == ins_oct) ? ins_mask : 8'h00);
    end
    mem_wdata[ROW_W-1 -: LEN_W] = (base_len < oct_p1) ? oct_p1 : base_len;
  end

  // Memory control: fetch on insert accept or when a read finds its window
  always_comb begin
    mem_we = (state == S_INS_WR);
    if (state == S_IDLE) begin
      mem_re    = in_valid && (kind == KIND_INSERT);
      mem_raddr = type_code[TYPE_W-1 -: WIN_W];
    end else begin
      mem_re    = found && !srch_next;
      mem_raddr = found_w;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[ins_code[TYPE_W-1 -: WIN_W]] <= mem_wdata;
    end
    if (mem_re) begin
      row_rdata <= row_mem[mem_raddr];
      rd_valid  <= present[mem_raddr];
    end
  end

  // Emit: pick the byte at the reader position within the fetched window
  logic [LEN_W-1:0]    cur_len;
  logic [POS_W-1:0]    pos0;
  logic [POS_W-1:0]    pos;
  logic [LEN_W:0]      len_p1;
  logic [OCT_IW-1:0]   oct_idx;
  logic [BYTE_W-1:0]   emit_byte;
  logic                at_end;

  always_comb begin
    cur_len = row_rdata[ROW_W-1 -: LEN_W];
    len_p1  = {1'b0, cur_len} + 7'd1;
    pos0    = (cur_w == rw) ? rp : '0;
    pos     = ({1'b0, pos0} > len_p1) ? '0 : pos0;
    oct_idx = OCT_IW'(pos - 6'd2);
    if (pos == 6'd0) begin
      emit_byte = cur_w;
    end else if (pos == 6'd1) begin
      emit_byte = {2'b00, cur_len};
    end else begin
      emit_byte = row_rdata[{oct_idx, 3'b000} +: BYTE_W];
    end
    at_end = ({1'b0, pos} == len_p1);
  end

  // Sequencer, presence vector, reader state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      present   <= '0;
      rw        <= '0;
      rp        <= '0;
      out_valid <= 1'b0;
      srch_next <= 1'b0;
    end else begin
      // Drop a taken item unless a new one loads below
      if (out_ready && (state != S_OUT)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (kind)
              KIND_CLEAR: begin
                present <= '0;
                rw      <= '0;
                rp      <= '0;
              end
              KIND_INSERT: begin
                ins_code <= type_code;
                state    <= S_INS_WR;
              end
              KIND_READ: begin
                srch_start <= rw;
                srch_wrap  <= 1'b1;
                srch_next  <= 1'b0;
                state      <= S_FIND;
              end
              default: begin
              end
            endcase
          end
        end
        S_INS_WR: begin
          present[ins_code[TYPE_W-1 -: WIN_W]] <= 1'b1;
          rw    <= '0;
          rp    <= '0;
          state <= S_IDLE;
        end
        S_FIND, S_FIND2: begin
          if (found) begin
            if (srch_next) begin
              res_last <= 1'b0;
              rw_pend  <= found_w;
              rp_pend  <= '0;
              state    <= S_OUT;
            end else begin
              cur_w <= found_w;
              state <= S_EMIT;
            end
          end else if (|above) begin
            srch_grp <= first_set16(above);
            state    <= S_FIND2;
          end else if (srch_wrap && (srch_start != '0)) begin
            // wrap once to the lowest window
            srch_start <= '0;
            srch_wrap  <= 1'b0;
          end else if (srch_next) begin
            // no window follows: final byte, restart the reader
            res_last <= 1'b1;
            rw_pend  <= '0;
            rp_pend  <= '0;
            state    <= S_OUT;
          end else begin
            // empty set: flag it and leave the reader where it is
            res_byte  <= '0;
            res_last  <= 1'b1;
            res_empty <= 1'b1;
            rw_pend   <= rw;
            rp_pend   <= rp;
            state     <= S_OUT;
          end
        end
        S_EMIT: begin
          res_byte  <= emit_byte;
          res_empty <= 1'b0;
          if (at_end) begin
            if (cur_w == LAST_WIN) begin
              res_last <= 1'b1;
              rw_pend  <= '0;
              rp_pend  <= '0;
              state    <= S_OUT;
            end else begin
              srch_start <= cur_w + 8'd1;
              srch_wrap  <= 1'b0;
              srch_next  <= 1'b1;
              state      <= S_FIND;
            end
          end else begin
            res_last <= 1'b0;
            rw_pend  <= cur_w;
            rp_pend  <= pos + 6'd1;
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            wire_byte <= res_byte;
            last_byte <= res_last;
            empty_set <= res_empty;
            rw        <= rw_pend;
            rp        <= rp_pend;
            srch_next <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (kind == KIND_CLEAR)) |=> (present == '0))
    else $error("clear left a window present");

  a_insert_marks: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_WR) |=> present[$past(ins_code[TYPE_W-1 -: WIN_W])])
    else $error("inserted window not marked present");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_set) |-> (last_byte && (wire_byte == '0)))
    else $error("empty set result not flagged as last zero byte");

  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !mem_re)
    else $error("row memory read and written in one cycle");

  a_out_not_lost: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(wire_byte)))
    else $error("pending result overwritten");

endmodule

/* bench/ntb_wire_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ntb_wire_checker
// Watches both channels of the NSEC type bitmap builder, keeps its own copy
// of the type set and the reader, and checks every wire byte in order.
// ----------------------------------------------------------------------------
module ntb_wire_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [ntb_pkg::KIND_W-1:0] kind,
  input  logic [ntb_pkg::TYPE_W-1:0] type_code,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [ntb_pkg::BYTE_W-1:0] wire_byte,
  input  logic                       last_byte,
  input  logic                       empty_set,
  output int                         fail_count,
  output int                         pending
);
  import ntb_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_val;
    logic              last;
    logic              empty;
  } wire_result_t;

  // Shadow of the type set and the reader
  logic [BYTE_W-1:0] oct_mem [WIN_N][OCT_N];
  logic [LEN_W-1:0]  win_len [WIN_N];
  logic [WIN_W-1:0]  rd_win;
  logic [POS_W-1:0]  rd_pos;

  // Wire bytes still owed by the block, oldest first
  wire_result_t wire_exp_q [$];

  // First window at or above start that holds a type; WIN_N when none
  function automatic int next_window(int start);
    for (int w = start; w < WIN_N; w++) begin
      if (win_len[w] != '0) return w;
    end
    return WIN_N;
  endfunction

  // Empty the set and restart the reader
  task automatic clear_set();
    for (int w = 0; w < WIN_N; w++) begin
      win_len[w] = '0;
      for (int o = 0; o < OCT_N; o++) oct_mem[w][o] = '0;
    end
    rd_win = '0;
    rd_pos = '0;
  endtask

  // Set the bit of one type and grow its window
  task automatic insert_type(logic [TYPE_W-1:0] code);
    logic [WIN_W-1:0] win;
    logic [7:0]       low;
    int               oct;
    win = code[15:8];
    low = code[7:0];
    oct = int'(low[7:3]);
    oct_mem[win][oct] = oct_mem[win][oct] | (OCT_TOP_BIT >> low[2:0]);
    if (int'(win_len[win]) < oct + 1) win_len[win] = LEN_W'(oct + 1);
    rd_win = '0;
    rd_pos = '0;
  endtask

  // Work out the next wire byte and advance the reader
  task automatic next_wire_byte(output wire_result_t res);
    int w;
    int nx;
    int len;
    int pos;
    res = '0;
    w = next_window(int'(rd_win));
    if (w >= WIN_N) w = next_window(0);
    if (w >= WIN_N) begin
      res.last  = 1'b1;
      res.empty = 1'b1;
      return;
    end
    if (w != int'(rd_win)) rd_pos = '0;
    len = int'(win_len[w]);
    pos = int'(rd_pos);
    if (pos > len + 1) pos = 0;
    if (pos == 0) res.byte_val = BYTE_W'(w);
    else if (pos == 1) res.byte_val = BYTE_W'(len);
    else res.byte_val = oct_mem[w][(pos - 2) & (OCT_N - 1)];
    if (pos == len + 1) begin
      nx = (w + 1 < WIN_N) ? next_window(w + 1) : WIN_N;
      if (nx >= WIN_N) begin
        res.last = 1'b1;
        rd_win   = '0;
      end else begin
        rd_win = WIN_W'(nx);
      end
      rd_pos = '0;
    end else begin
      rd_win = WIN_W'(w);
      rd_pos = POS_W'(pos + 1);
    end
  endtask

  always @(posedge clk) begin : monitor
    wire_result_t want;
    wire_result_t fresh;
    if (rst) begin
      clear_set();
      wire_exp_q.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      // Compare a delivered byte with the oldest expectation
      if (out_valid && out_ready) begin
        if (wire_exp_q.size() == 0) begin
          $display("%0t: unexpected wire byte %02h last %0b empty %0b", $time,
                   wire_byte, last_byte, empty_set);
          fail_count++;
        end else begin
          want = wire_exp_q.pop_front();
          // The byte carries no meaning when the set is empty
          if (!want.empty && wire_byte !== want.byte_val) begin
            $display("%0t: wire_byte expected %02h actual %02h", $time,
                     want.byte_val, wire_byte);
            fail_count++;
          end
          if (last_byte !== want.last) begin
            $display("%0t: last_byte expected %0b actual %0b", $time,
                     want.last, last_byte);
            fail_count++;
          end
          if (empty_set !== want.empty) begin
            $display("%0t: empty_set expected %0b actual %0b", $time,
                     want.empty, empty_set);
            fail_count++;
          end
        end
      end
      // Apply an accepted item to the shadow set
      if (in_valid && in_ready) begin
        case (kind)
          KIND_CLEAR:  clear_set();
          KIND_INSERT: insert_type(type_code);
          KIND_READ: begin
            next_wire_byte(fresh);
            wire_exp_q = {wire_exp_q, fresh};
          end
          default: ;
        endcase
      end
      pending = wire_exp_q.size();
    end
  end

endmodule

/* bench/tb_nsec_type_bitmap_builder_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nsec_type_bitmap_builder_core
// Drives clear, insert, read and unused-kind items into the type bitmap builder with
// random gaps and output stalls; the wire checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_nsec_type_bitmap_builder_core;
  import ntb_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 1300;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [KIND_W-1:0] kind = KIND_CLEAR;
  logic [TYPE_W-1:0] type_code = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] wire_byte;
  logic              last_byte;
  logic              empty_set;

  int fail_count;
  int pending;
  int items_sent;
  int cycle_count;
  int stall_left;
  bit calm = 1'b0;

  nsec_type_bitmap_builder_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .type_code (type_code),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .wire_byte (wire_byte),
    .last_byte (last_byte),
    .empty_set (empty_set)
  );

  ntb_wire_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .type_code  (type_code),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .wire_byte  (wire_byte),
    .last_byte  (last_byte),
    .empty_set  (empty_set),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached", $time);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Sender gap: mostly none or short, now and then long
  function automatic int idle_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  // Receiver stall: lower ready for a random stretch
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      out_ready <= 1'b0;
      if ($urandom_range(0, 99) < 70) stall_left = $urandom_range(0, 2);
      else if ($urandom_range(0, 99) < 85) stall_left = $urandom_range(3, 10);
      else stall_left = $urandom_range(20, 50);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one item and hold it until accepted
  task automatic send_item(logic [KIND_W-1:0] k, logic [TYPE_W-1:0] code);
    int gap;
    in_valid  <= 1'b1;
    kind      <= k;
    type_code <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (k != KIND_UNUSED) items_sent++;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_reads(int n);
    repeat (n) send_item(KIND_READ, TYPE_W'($urandom));
  endtask

  // Hold off until every wire byte is back, then let the block settle
  task automatic drain_wait();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Type code biased toward few windows and short bitmaps
  function automatic logic [TYPE_W-1:0] rand_type();
    logic [7:0] win;
    logic [7:0] low;
    int         r;
    r = $urandom_range(0, 9);
    if (r < 4) win = 8'($urandom_range(0, 3));
    else if (r < 7) win = 8'($urandom_range(0, 255));
    else if (r == 7) win = 8'hFF;
    else if (r == 8) win = 8'h00;
    else win = 8'($urandom_range(250, 255));
    low = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 47))
                                     : 8'($urandom_range(0, 255));
    return {win, low};
  endfunction

  initial begin : stimulus
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty read, ignored kind, both type extremes, wrap of reader
    send_item(KIND_READ, 16'h0000);
    send_item(KIND_UNUSED, 16'hFFFF);
    send_item(KIND_INSERT, 16'h0000);
    send_reads(4);
    send_item(KIND_INSERT, 16'hFFFF);
    send_reads(5);
    send_item(KIND_INSERT, 16'h0107);
    send_reads(3);
    send_item(KIND_CLEAR, 16'hFFFF);
    send_item(KIND_READ, 16'hFFFF);
    send_item(KIND_INSERT, 16'h3A5C);
    send_reads(4);
    drain_wait();

    // Random: mostly build-then-read sequences, some noise
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      calm <= ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 12) begin
        repeat ($urandom_range(1, 4))
          send_item(KIND_W'($urandom_range(0, 3)), TYPE_W'($urandom));
      end else begin
        if ($urandom_range(0, 3) == 0) send_item(KIND_CLEAR, TYPE_W'($urandom));
        repeat ($urandom_range(0, 6)) send_item(KIND_INSERT, rand_type());
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 40);
        // Break a read sequence with a late insert now and then
        if ($urandom_range(0, 6) == 0) begin
          send_reads($urandom_range(1, n));
          send_item(KIND_INSERT, rand_type());
        end
        send_reads(n);
      end
      if ($urandom_range(0, 19) == 0) drain_wait();
    end

    calm <= 1'b0;
    drain_wait();
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (pending != 0) $display("%0t: %0d wire bytes never arrived", $time, pending);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
